@@ rtl/complex_arith_unit_macros.svh @@
// Assertion macros for the complex arithmetic unit.
// Included by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define CAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset
`define CAU_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CAU_ASSERT(lbl, prop, msg)
`define CAU_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
// No dependencies; used by every other RTL file except the assertion macros header.
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int WORD_W        = 16;
    localparam int PROD_W        = 32;
    localparam int SUM_W         = 33;
    localparam int QUO_BITS      = 17;
    localparam int Q_DEPTH       = 2;
    localparam int POS_LIMIT     = 32767;
    localparam int NEG_LIMIT     = 32768;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 16'sh7FFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    // One classified item on its way from the front end to the back end
    typedef struct packed {
        action_t                   act;
        logic                      dz;
        logic signed [SUM_W-1:0]   x_re;
        logic signed [SUM_W-1:0]   x_im;
        logic        [PROD_W-1:0]  den;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/cau_in_if.sv @@
// Operand channel of the complex arithmetic unit: valid/ready plus operation and operands.
// Depends on cau_pkg for the word width.
`default_nettype none

interface cau_in_if;
    logic                                 valid;
    logic                                 ready;
    logic        [1:0]                    action;
    logic signed [cau_pkg::WORD_W-1:0]    first_re;
    logic signed [cau_pkg::WORD_W-1:0]    first_im;
    logic signed [cau_pkg::WORD_W-1:0]    second_re;
    logic signed [cau_pkg::WORD_W-1:0]    second_im;

    modport source (output valid, action, first_re, first_im, second_re, second_im,
                    input ready);
    modport sink   (input valid, action, first_re, first_im, second_re, second_im,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/cau_out_if.sv @@
// Result channel of the complex arithmetic unit: valid/ready plus result parts and status.
// Depends on cau_pkg for the word width.
`default_nettype none

interface cau_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cau_pkg::WORD_W-1:0]    result_re;
    logic signed [cau_pkg::WORD_W-1:0]    result_im;
    logic        [1:0]                    status;

    modport source (output valid, result_re, result_im, status, input ready);
    modport sink   (input valid, result_re, result_im, status, output ready);
endinterface

`default_nettype wire

@@ rtl/cau_front.sv @@
// Front end: takes operand beats, forms the partial products and classifies each item.
// Depends on cau_pkg, cau_in_if and the assertion macros.
`default_nettype none
`include "complex_arith_unit_macros.svh"

module cau_front (
    input  logic            clk,
    input  logic            rst_n,
    cau_in_if.sink          cmd,
    input  logic            q_full,
    output logic            q_push,
    output cau_pkg::entry_t q_entry
);
    import cau_pkg::*;

    logic                       valid_reg, valid_next;
    action_t                    act_reg;
    logic                       dz_reg;
    logic signed [PROD_W-1:0]   ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [WORD_W:0]     sre_reg, sim_reg;
    logic                       accept;

    // Take a beat whenever the holding register is empty or drains this cycle
    assign cmd.ready = !valid_reg || !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign q_push    = valid_reg && !q_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture products and the add/subtract result on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action_t'(cmd.action);
            dz_reg  <= (cmd.second_re == '0) && (cmd.second_im == '0);
            ac_reg  <= cmd.first_re  * cmd.second_re;
            bd_reg  <= cmd.first_im  * cmd.second_im;
            ad_reg  <= cmd.first_re  * cmd.second_im;
            bc_reg  <= cmd.first_im  * cmd.second_re;
            cc_reg  <= cmd.second_re * cmd.second_re;
            dd_reg  <= cmd.second_im * cmd.second_im;
            if (action_t'(cmd.action) == ACT_SUB)
            begin
                sre_reg <= (WORD_W+1)'(cmd.first_re) - (WORD_W+1)'(cmd.second_re);
                sim_reg <= (WORD_W+1)'(cmd.first_im) - (WORD_W+1)'(cmd.second_im);
            end
            else
            begin
                sre_reg <= (WORD_W+1)'(cmd.first_re) + (WORD_W+1)'(cmd.second_re);
                sim_reg <= (WORD_W+1)'(cmd.first_im) + (WORD_W+1)'(cmd.second_im);
            end
        end
    end

    // Classify: pick the numerators for the back end
    always_comb
    begin
        q_entry.act = act_reg;
        q_entry.dz  = dz_reg;
        q_entry.den = cc_reg[PROD_W-1:0] + dd_reg[PROD_W-1:0];
        unique case (act_reg)
            ACT_ADD, ACT_SUB:
            begin
                q_entry.x_re = SUM_W'(sre_reg);
                q_entry.x_im = SUM_W'(sim_reg);
            end
            ACT_MUL:
            begin
                q_entry.x_re = SUM_W'(ac_reg) - SUM_W'(bd_reg);
                q_entry.x_im = SUM_W'(ad_reg) + SUM_W'(bc_reg);
            end
            default:
            begin
                q_entry.x_re = SUM_W'(ac_reg) + SUM_W'(bd_reg);
                q_entry.x_im = SUM_W'(bc_reg) - SUM_W'(ad_reg);
            end
        endcase
    end

    `CAU_ASSERT(fr_hold_when_full, (valid_reg && q_full) |=> valid_reg, "front dropped a held item")

endmodule

`default_nettype wire

@@ rtl/cau_queue.sv @@
// Short queue that decouples the front end from the back end.
// Depends on cau_pkg and the assertion macros.
`default_nettype none
`include "complex_arith_unit_macros.svh"

module cau_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cau_pkg::entry_t entry_in,
    output logic            full,
    output logic            valid,
    output cau_pkg::entry_t entry_out,
    input  logic            pop
);
    import cau_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    entry_t             slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (PTR_W+1)'(Q_DEPTH));
    assign valid     = (count_reg != '0);
    assign entry_out = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

    `CAU_NEVER(q_count_range, count_reg > (PTR_W+1)'(Q_DEPTH), "queue occupancy out of range")
    `CAU_ASSERT(q_ptr_match, (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree with occupancy")

endmodule

`default_nettype wire

@@ rtl/cau_back.sv @@
// Back end: rounding, saturation and a pipelined restoring divider, one quotient bit a stage.
// Depends on cau_pkg, cau_out_if and the assertion macros.
`default_nettype none
`include "complex_arith_unit_macros.svh"

module cau_back #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  cau_pkg::entry_t q_entry,
    output logic            q_pop,
    cau_out_if.source       res
);
    import cau_pkg::*;

    // Scaled dividend: numerator << (FRAC_BITS+1) plus the denominator, half the divisor
    localparam int NUM_W   = SUM_W + FRAC_BITS + 1;
    localparam int MAG_W   = NUM_W - 1;
    localparam int DV_W    = PROD_W + 1;
    localparam int RW      = (MAG_W > DV_W + QUO_BITS) ? MAG_W : DV_W + QUO_BITS;
    localparam int RND_W   = SUM_W + 1;
    localparam int CLAMP_W = 48;
    localparam int NST     = QUO_BITS + 2;

    localparam logic signed [RND_W-1:0]   HALF  = RND_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [CLAMP_W-1:0] C_MAX = CLAMP_W'(POS_LIMIT);
    localparam logic signed [CLAMP_W-1:0] C_MIN = -CLAMP_W'(NEG_LIMIT);

    typedef struct packed {
        logic signed [WORD_W-1:0] val;
        logic                     ovf;
    } clamp_t;

    typedef struct packed {
        logic                neg;
        logic                sat;
        logic [RW-1:0]       rem;
        logic [QUO_BITS-1:0] quo;
    } part_t;

    typedef struct packed {
        logic                     div;
        logic signed [WORD_W-1:0] re;
        logic signed [WORD_W-1:0] im;
        status_t                  st;
        logic [DV_W-1:0]          dv;
        part_t                    pr;
        part_t                    pi;
    } stage_t;

    function automatic clamp_t clamp16(input logic signed [CLAMP_W-1:0] v);
        clamp_t r;
        r.ovf = 1'b0;
        r.val = v[WORD_W-1:0];
        if (v > C_MAX)
        begin
            r.ovf = 1'b1;
            r.val = WORD_MAX;
        end
        else if (v < C_MIN)
        begin
            r.ovf = 1'b1;
            r.val = WORD_MIN;
        end
        return r;
    endfunction

    // One restoring step: subtract the shifted divisor if it fits
    function automatic part_t div_step(input part_t p, input logic [RW-1:0] trial);
        part_t r;
        logic  ge;
        r  = p;
        ge = (p.rem >= trial);
        if (ge)
        begin
            r.rem = p.rem - trial;
        end
        r.quo = {p.quo[QUO_BITS-2:0], ge};
        return r;
    endfunction

    // Turn magnitude quotient into a floored, saturated signed word
    function automatic clamp_t finish_part(input part_t p);
        logic [QUO_BITS:0] m;
        clamp_t            r;
        m     = {1'b0, p.quo} + {{QUO_BITS{1'b0}}, (p.rem != '0)};
        r.ovf = 1'b0;
        r.val = '0;
        if (p.sat)
        begin
            r.ovf = 1'b1;
            r.val = p.neg ? WORD_MIN : WORD_MAX;
        end
        else if (!p.neg)
        begin
            if (p.quo > QUO_BITS'(POS_LIMIT))
            begin
                r.ovf = 1'b1;
                r.val = WORD_MAX;
            end
            else
            begin
                r.val = p.quo[WORD_W-1:0];
            end
        end
        else
        begin
            if (m > (QUO_BITS+1)'(NEG_LIMIT))
            begin
                r.ovf = 1'b1;
                r.val = WORD_MIN;
            end
            else
            begin
                r.val = (~m[WORD_W-1:0]) + 1'b1;
            end
        end
        return r;
    endfunction

    stage_t               stage_reg  [NST];
    stage_t               stage_next [NST];
    stage_t               prep_stage;
    logic [NST-1:0]       valid_reg;
    logic                 res_valid_reg;
    logic signed [WORD_W-1:0] re_reg, im_reg, re_next, im_next;
    status_t              st_reg, st_next;
    logic                 adv;

    logic signed [NUM_W-1:0]  num_re, num_im;
    logic        [NUM_W-1:0]  abs_re, abs_im;
    logic signed [RND_W-1:0]  rnd_re, rnd_im, shr_re, shr_im;
    clamp_t                   c_re, c_im, f_re, f_im;
    stage_t                   fin;

    // Whole pipeline advances unless the output beat is stuck
    assign adv   = !res_valid_reg || res.ready;
    assign q_pop = adv && q_valid;

    // Prepare: round products, clamp sums, scale the dividend
    always_comb
    begin
        num_re = ($signed({{(NUM_W-SUM_W){q_entry.x_re[SUM_W-1]}}, q_entry.x_re})
                  <<< (FRAC_BITS + 1))
                 + $signed({{(NUM_W-PROD_W){1'b0}}, q_entry.den});
        num_im = ($signed({{(NUM_W-SUM_W){q_entry.x_im[SUM_W-1]}}, q_entry.x_im})
                  <<< (FRAC_BITS + 1))
                 + $signed({{(NUM_W-PROD_W){1'b0}}, q_entry.den});
        abs_re = num_re[NUM_W-1] ? (~num_re + 1'b1) : num_re;
        abs_im = num_im[NUM_W-1] ? (~num_im + 1'b1) : num_im;
        rnd_re = $signed({q_entry.x_re[SUM_W-1], q_entry.x_re}) + HALF;
        rnd_im = $signed({q_entry.x_im[SUM_W-1], q_entry.x_im}) + HALF;
        shr_re = rnd_re >>> FRAC_BITS;
        shr_im = rnd_im >>> FRAC_BITS;

        c_re = '0;
        c_im = '0;
        prep_stage        = '0;
        prep_stage.dv     = {q_entry.den, 1'b0};
        prep_stage.pr.neg = num_re[NUM_W-1];
        prep_stage.pi.neg = num_im[NUM_W-1];
        prep_stage.pr.rem = RW'(abs_re[MAG_W-1:0]);
        prep_stage.pi.rem = RW'(abs_im[MAG_W-1:0]);
        unique case (q_entry.act)
            ACT_ADD, ACT_SUB:
            begin
                c_re = clamp16(CLAMP_W'($signed(q_entry.x_re)));
                c_im = clamp16(CLAMP_W'($signed(q_entry.x_im)));
            end
            ACT_MUL:
            begin
                c_re = clamp16(CLAMP_W'(shr_re));
                c_im = clamp16(CLAMP_W'(shr_im));
            end
            default:
            begin
                c_re = '0;
                c_im = '0;
            end
        endcase
        prep_stage.div = (q_entry.act == ACT_DIV) && !q_entry.dz;
        prep_stage.re  = c_re.val;
        prep_stage.im  = c_im.val;
        if ((q_entry.act == ACT_DIV) && q_entry.dz)
        begin
            prep_stage.st = ST_DIVZ;
        end
        else if (c_re.ovf || c_im.ovf)
        begin
            prep_stage.st = ST_OVF;
        end
        else
        begin
            prep_stage.st = ST_OK;
        end
    end

    // Range check, then one quotient bit per stage, most significant first
    always_comb
    begin
        stage_next[0] = prep_stage;
        for (int k = 1; k < NST; k++)
        begin
            stage_next[k] = stage_reg[k-1];
            if (k == 1)
            begin
                stage_next[k].pr.sat = stage_reg[k-1].pr.rem >=
                                       (RW'(stage_reg[k-1].dv) << QUO_BITS);
                stage_next[k].pi.sat = stage_reg[k-1].pi.rem >=
                                       (RW'(stage_reg[k-1].dv) << QUO_BITS);
            end
            else
            begin
                stage_next[k].pr = div_step(stage_reg[k-1].pr,
                                            RW'(stage_reg[k-1].dv) << (QUO_BITS + 1 - k));
                stage_next[k].pi = div_step(stage_reg[k-1].pi,
                                            RW'(stage_reg[k-1].dv) << (QUO_BITS + 1 - k));
            end
        end
    end

    // Hold the stages while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Finish: floor the quotients and pick the status
    always_comb
    begin
        fin  = stage_reg[NST-1];
        f_re = finish_part(fin.pr);
        f_im = finish_part(fin.pi);
        if (fin.div)
        begin
            re_next = f_re.val;
            im_next = f_im.val;
            st_next = (f_re.ovf || f_im.ovf) ? ST_OVF : ST_OK;
        end
        else
        begin
            re_next = fin.re;
            im_next = fin.im;
            st_next = fin.st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[NST-2:0], q_valid};
            res_valid_reg <= valid_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.result_re = re_reg;
    assign res.result_im = im_reg;
    assign res.status    = st_reg;

    `CAU_ASSERT(bk_drain, (adv && valid_reg[NST-1]) |=> res_valid_reg,
                "back end lost a finished item")
    `CAU_ASSERT(bk_divz_zero,
                (res_valid_reg && st_reg == ST_DIVZ) |-> (re_reg == '0 && im_reg == '0),
                "zero divisor result not zero")

endmodule

`default_nettype wire

@@ rtl/complex_arith_unit.sv @@
// Top level of the complex arithmetic unit: front end, queue and back end.
// Depends on cau_pkg, cau_in_if, cau_out_if, cau_front, cau_queue and cau_back.
//
//   channel | dir | beat contents
//   cmd     | in  | action, first_re, first_im, second_re, second_im
//   res     | out | result_re, result_im, status
//
// One beat accepted per cycle while the front end is not held by a full queue; a beat
// passes through the input register, which loads on the edge that takes it, then the queue,
// prepare, range-check, 17 restoring divider stages and the output register.
// Reset clears only valid flags, queue pointers and queue occupancy; item data is not reset.
// A stalled output freezes the back end; the two-entry queue lets the front keep going until it fills.
`default_nettype none

module complex_arith_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    cmd,
    cau_out_if.source res
);
    import cau_pkg::*;

    logic   q_push, q_full, q_valid, q_pop;
    entry_t push_entry, head_entry;

    cau_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    cau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (push_entry),
        .full      (q_full),
        .valid     (q_valid),
        .entry_out (head_entry),
        .pop       (q_pop)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (head_entry),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for complex_arith_unit: complex add, subtract, multiply, divide.
// Depends on cau_pkg, cau_in_if, cau_out_if and the complex_arith_unit RTL.
`default_nettype none

module testbench;
    import cau_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [1:0]         st;
    } cresult_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cau_in_if  cmd ();
    cau_out_if res ();

    complex_arith_unit #(.FRAC_BITS(FB)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    cresult_t expected_results[$];
    int       n_errors = 0;
    int       n_results = 0;
    int       burst_left = 0;
    int       gap_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor division for positive divisor
    function automatic longint floor_quot(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Clamp one part to 16 bits, flag overflow
    function automatic logic signed [15:0] clamp_part(longint v, inout bit ovf);
        if (v > POS_LIMIT)
        begin
            ovf = 1'b1;
            return WORD_MAX;
        end
        if (v < -NEG_LIMIT)
        begin
            ovf = 1'b1;
            return WORD_MIN;
        end
        return v[15:0];
    endfunction

    // Work out the complex result of one operation
    function automatic cresult_t complex_result(action_t act, logic signed [15:0] a,
                                                logic signed [15:0] b, logic signed [15:0] c,
                                                logic signed [15:0] d);
        longint   one;
        longint   re;
        longint   im;
        longint   den;
        bit       ovf;
        cresult_t r;
        one = longint'(1) << FB;
        re = 0;
        im = 0;
        ovf = 1'b0;
        r.st = ST_OK;
        case (act)
            ACT_ADD:
            begin
                re = longint'(a) + c;
                im = longint'(b) + d;
            end
            ACT_SUB:
            begin
                re = longint'(a) - c;
                im = longint'(b) - d;
            end
            ACT_MUL:
            begin
                re = floor_quot(longint'(a) * c - longint'(b) * d + one / 2, one);
                im = floor_quot(longint'(a) * d + longint'(b) * c + one / 2, one);
            end
            default:
            begin
                den = longint'(c) * c + longint'(d) * d;
                if (den == 0)
                    r.st = ST_DIVZ;
                else
                begin
                    re = floor_quot(2 * (longint'(a) * c + longint'(b) * d) * one + den,
                                    2 * den);
                    im = floor_quot(2 * (longint'(b) * c - longint'(a) * d) * one + den,
                                    2 * den);
                end
            end
        endcase
        if (r.st == ST_OK)
        begin
            r.re = clamp_part(re, ovf);
            r.im = clamp_part(im, ovf);
            if (ovf)
                r.st = ST_OVF;
        end
        else
        begin
            r.re = '0;
            r.im = '0;
        end
        return r;
    endfunction

    // Send one beat, honouring the burst/gap pattern
    task automatic send_item(action_t act, logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, logic signed [15:0] d);
        while (gap_left > 0)
        begin
            gap_left--;
            @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.action    <= act;
        cmd.first_re  <= a;
        cmd.first_im  <= b;
        cmd.second_re <= c;
        cmd.second_im <= d;
        expected_results.push_back(complex_result(act, a, b, c, d));
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_left > 0)
                cmd.valid <= 1'b0;
        end
    endtask

    // Drop valid once the stimulus is done
    task automatic idle_sender();
        cmd.valid <= 1'b0;
        gap_left = 0;
    endtask

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(0, 5))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 16'($signed($urandom_range(0, 8191)) - 4096);
            3: return 16'($signed($urandom_range(0, 127)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed corners: field extremes, every operation, zero divisor, ties
    task automatic test_directed();
        logic signed [15:0] ext[4];
        ext = '{WORD_MAX, WORD_MIN, 16'sd0, -16'sd1};
        for (int op = 0; op < 4; op++)
        begin
            send_item(action_t'(op), WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
            send_item(action_t'(op), WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
            send_item(action_t'(op), ext[op], 16'sh1000, 16'sh1000, ext[3 - op]);
        end
        // zero divisor
        send_item(ACT_DIV, 16'sh1234, -16'sh0567, 16'sd0, 16'sd0);
        send_item(ACT_DIV, WORD_MIN, WORD_MIN, 16'sd0, 16'sd0);
        // rounding ties and smallest magnitudes
        send_item(ACT_MUL, 16'sd1, 16'sd0, 16'sh0800, 16'sd0);
        send_item(ACT_MUL, -16'sd1, 16'sd0, 16'sh0800, 16'sd0);
        send_item(ACT_DIV, 16'sd1, 16'sd0, 16'sd2, 16'sd0);
        send_item(ACT_DIV, -16'sd1, 16'sd0, 16'sd2, 16'sd0);
        send_item(ACT_DIV, 16'sh1000, 16'sd0, 16'sd1, 16'sd0);
        send_item(ACT_DIV, 16'sd1, 16'sd1, 16'sd1, -16'sd1);
    endtask

    // Random operands of every operation
    task automatic test_random(int count);
        action_t act;
        logic signed [15:0] c;
        logic signed [15:0] d;
        for (int i = 0; i < count; i++)
        begin
            act = action_t'($urandom_range(0, 3));
            c = rand_word();
            d = rand_word();
            if (act == ACT_DIV && $urandom_range(0, 40) == 0)
            begin
                c = '0;
                d = '0;
            end
            send_item(act, rand_word(), rand_word(), c, d);
        end
    endtask

    // Receiver stall pattern: runs of ready and runs of stall
    initial
    begin
        int run;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 40);
            res.ready <= 1'b1;
            repeat (run) @(posedge clk);
            if ($urandom_range(0, 2) != 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        cresult_t want;
        if (rst_n && res.valid && res.ready)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Unexpected result beat: re=%0d im=%0d st=%0d",
                             res.result_re, res.result_im, res.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res.result_re !== want.re || res.result_im !== want.im
                    || res.status !== want.st)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("Mismatch: expected re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                                 want.re, want.im, want.st,
                                 res.result_re, res.result_im, res.status);
                end
            end
        end
    end

    initial
    begin
        cmd.valid     <= 1'b0;
        cmd.action    <= ACT_ADD;
        cmd.first_re  <= '0;
        cmd.first_im  <= '0;
        cmd.second_re <= '0;
        cmd.second_im <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1350);
        idle_sender();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Checked %0d results over add, subtract, multiply and divide,", n_results);
        $display("including saturation, zero divisors and rounding ties; %0d errors.", n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timeout: %0d results still outstanding", expected_results.size());
        $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
